/* src/ptbma_pkg.sv */
`timescale 1ns / 1ps
package ptbma_pkg;
    localparam int unsigned XW = 13;
    localparam int unsigned WW = 12;
    localparam int unsigned IDW = 16;
    localparam int unsigned SXW = 17;
    localparam int unsigned SWW = 16;
    localparam int unsigned NW = 7;
    // ring depth per slot; the head pointer wraps on its own bits
    localparam int unsigned MAX_WINDOW = 8;
    localparam int unsigned PW = 3;
    localparam logic [3:0] REG_WINDOW = 4'd0;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic [WW-1:0] w;
        logic [WW-1:0] h;
    } t_box;

    typedef struct packed {
        logic signed [SXW-1:0] x;
        logic signed [SXW-1:0] y;
        logic        [SWW-1:0] w;
        logic        [SWW-1:0] h;
    } t_sum;

    typedef struct packed {
        logic           hit;
        logic           free;
        logic [IDW-1:0] id;
    } t_probe;
endpackage

/* src/ptbma_cell.sv */
`timescale 1ns / 1ps
// one track slot: holds its id, flags and box ring; probes a passing id
module ptbma_cell
    import ptbma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_probe                i_probe,
    output t_probe                o_probe,
    input  logic                  i_sel,
    input  logic                  i_alloc,
    input  logic                  i_eof,
    input  logic [NW-1:0]         i_win,
    input  t_box                  i_box,
    input  logic [PW-1:0]         i_rd_idx,
    output t_box                  o_rd_box,
    output logic [NW-1:0]         o_count,
    output logic [PW-1:0]         o_head,
    output logic                  o_match,
    output logic                  o_free
);
    logic          r_valid, r_seen;
    logic [IDW-1:0] r_id;
    logic [NW-1:0]  r_count;
    logic [PW-1:0]  r_head;
    t_box           r_ring [MAX_WINDOW];
    logic [NW-1:0]  n_count;

    assign o_match = r_valid && (r_id == i_probe.id);
    assign o_free  = !r_valid;
    // local hit/free flags are ORed into the chain
    assign o_probe.id   = i_probe.id;
    assign o_probe.hit  = i_probe.hit | o_match;
    assign o_probe.free = i_probe.free | o_free;
    assign o_rd_box = r_ring[i_rd_idx];
    assign o_count  = r_count;
    assign o_head   = r_head;

    always_comb begin
        n_count = (i_alloc ? '0 : r_count) + NW'(1);
        if (n_count > i_win) n_count = i_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_seen  <= 1'b0;
            r_count <= '0;
            r_head  <= '0;
        end else if (i_eof) begin
            if (!r_seen) r_valid <= 1'b0;
            r_seen <= 1'b0;
        end else if (i_sel) begin
            r_valid <= 1'b1;
            r_seen  <= 1'b1;
            r_count <= n_count;
            r_head  <= (i_alloc ? PW'(0) : r_head) + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sel) begin
            r_ring[i_alloc ? PW'(0) : r_head] <= i_box;
            if (i_alloc) r_id <= i_probe.id;
        end
    end
endmodule

/* src/ptbma_div.sv */
`timescale 1ns / 1ps
// restoring divider for round(sum/n), half away from zero, one bit a cycle
module ptbma_div
    import ptbma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_neg,
    input  logic [SXW:0]          i_mag2n,
    input  logic [NW:0]           i_den2,
    output logic                  o_done,
    output logic signed [SXW:0]   o_q
);
    logic [SXW:0]  r_quo;
    logic [NW+1:0] r_rem;
    logic [NW:0]   r_den;
    logic          r_neg, r_busy;
    logic [4:0]    r_cnt;
    logic [NW+1:0] n_rem;

    assign n_rem = {r_rem[NW:0], r_quo[SXW]};
    assign o_done = r_busy && (r_cnt == 5'd0);
    assign o_q = r_neg ? -$signed(r_quo) : $signed(r_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'(SXW + 1);
        end else if (r_busy) begin
            if (r_cnt == 5'd0) r_busy <= 1'b0;
            else r_cnt <= r_cnt - 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_mag2n;
            r_rem <= '0;
            r_den <= i_den2;
            r_neg <= i_neg;
        end else if (r_busy && r_cnt != 5'd0) begin
            if (n_rem >= {1'b0, r_den}) begin
                r_rem <= n_rem - {1'b0, r_den};
                r_quo <= {r_quo[SXW-1:0], 1'b1};
            end else begin
                r_rem <= n_rem;
                r_quo <= {r_quo[SXW-1:0], 1'b0};
            end
        end
    end
endmodule

/* src/per_track_box_moving_average_top.sv */
`timescale 1ns / 1ps
// channel | dir | transfer
// s_axis  | in  | tuser=kind, tdata=track_id,x,y,w,h
// m_axis  | out | tdata=smooth x,y,w,h,table_full
// apb     | in  | averaging window length at address 0
// a box is probed, then its ring is summed (n = boxes held, 1..8), then four
// divides run on one shared divider and the result goes into the output register;
// an end of frame only updates the slot flags
// a box that finds the table full is returned straight from its probe cycle
// the chain of slot cells is probed in one pass; sync active-low reset
// clears all slot flags; a result waits in the output register under stall
module per_track_box_moving_average_top
    import ptbma_pkg::*;
#(
    parameter int unsigned MAX_TRACKS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // track_id, box_x, box_y, box_w, box_h
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // smooth x, y, w, h, table_full
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned SW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001, ST_SUM = 5'b00010, ST_DIV = 5'b00100,
        ST_WAIT = 5'b01000, ST_OUT = 5'b10000
    } t_state;

    t_state r_state;
    logic [3:0] r_win;
    logic [SW-1:0] r_slot;
    logic [NW-1:0] r_n, r_i;
    logic [PW-1:0] r_pos;
    t_sum r_sum;
    logic [1:0] r_fld;
    logic [XW-1:0] r_mx, r_my;
    logic [WW-1:0] r_mw, r_mh;
    logic r_full, r_oval;

    t_probe chain [MAX_TRACKS+1];
    logic [MAX_TRACKS-1:0] match, free, sel;
    t_box rd_box [MAX_TRACKS];
    logic [NW-1:0] cnt [MAX_TRACKS];
    logic [PW-1:0] head [MAX_TRACKS];
    logic [NW-1:0] win_eff;
    logic acc, eof, boxin;
    logic [SW-1:0] hit_idx, free_idx;
    t_box in_box, cur_box;
    logic div_start, div_done, div_neg;
    logic signed [SXW:0] div_q, cur_s;
    logic [SXW:0] mag2n;

    assign pready = 1'b1;
    assign prdata = {28'd0, r_win};
    assign s_axis_tready = (r_state == ST_IDLE) && !r_oval;
    assign acc   = s_axis_tvalid && s_axis_tready;
    assign eof   = acc && s_axis_tuser;
    assign boxin = acc && !s_axis_tuser;
    assign in_box = '{x: s_axis_tdata[28:16], y: s_axis_tdata[41:29],
                      w: s_axis_tdata[53:42], h: s_axis_tdata[65:54]};

    always_comb begin
        if (r_win == 4'd0) win_eff = NW'(1);
        else if (NW'(r_win) > NW'(MAX_WINDOW)) win_eff = NW'(MAX_WINDOW);
        else win_eff = NW'(r_win);
    end

    assign chain[0] = '{hit: 1'b0, free: 1'b0, id: s_axis_tdata[15:0]};

    // lowest matching and lowest free slot
    always_comb begin
        hit_idx = '0;
        free_idx = '0;
        for (int k = MAX_TRACKS - 1; k >= 0; k--) begin
            if (match[k]) hit_idx = SW'(k);
            if (free[k]) free_idx = SW'(k);
        end
    end

    for (genvar g = 0; g < MAX_TRACKS; g++) begin : g_cell
        assign sel[g] = boxin && (chain[MAX_TRACKS].hit ? hit_idx == SW'(g)
                        : chain[MAX_TRACKS].free && free_idx == SW'(g));
        ptbma_cell u_cell (
            .i_clk, .i_rst_n,
            .i_probe(chain[g]), .o_probe(chain[g+1]),
            .i_sel(sel[g]), .i_alloc(!chain[MAX_TRACKS].hit), .i_eof(eof),
            .i_win(win_eff), .i_box(in_box),
            .i_rd_idx(r_pos), .o_rd_box(rd_box[g]),
            .o_count(cnt[g]), .o_head(head[g]),
            .o_match(match[g]), .o_free(free[g]));
    end

    assign cur_box = rd_box[r_slot];

    always_comb begin
        case (r_fld)
            2'd0: cur_s = (SXW+1)'(r_sum.x);
            2'd1: cur_s = (SXW+1)'(r_sum.y);
            2'd2: cur_s = $signed({2'b00, r_sum.w});
            default: cur_s = $signed({2'b00, r_sum.h});
        endcase
    end
    assign div_neg = cur_s[SXW];
    assign mag2n = ((div_neg ? -cur_s : cur_s) <<< 1) + (SXW+1)'(r_n);
    assign div_start = (r_state == ST_DIV);

    ptbma_div u_div (
        .i_clk, .i_rst_n, .i_start(div_start), .i_neg(div_neg),
        .i_mag2n(mag2n), .i_den2({r_n, 1'b0}),
        .o_done(div_done), .o_q(div_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= 4'd4;
        end else if (psel && penable && pwrite && pready
                     && paddr == REG_WINDOW[1:0]) begin
            r_win <= pwdata[3:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_oval  <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) r_oval <= 1'b0;
            case (r_state)
                ST_IDLE: if (boxin) begin
                    if (!chain[MAX_TRACKS].hit && !chain[MAX_TRACKS].free) begin
                        r_oval <= 1'b1;
                    end else begin
                        r_state <= ST_SUM;
                    end
                end
                // last ring entry is added on the same edge
                ST_SUM: if (r_i != '0 && r_i == r_n) r_state <= ST_DIV;
                ST_DIV: r_state <= ST_WAIT;
                ST_WAIT: if (div_done) begin
                    r_state <= (r_fld == 2'd3) ? ST_OUT : ST_DIV;
                end
                ST_OUT: begin
                    r_oval  <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (boxin) begin
                r_slot <= chain[MAX_TRACKS].hit ? hit_idx : free_idx;
                r_full <= !chain[MAX_TRACKS].hit && !chain[MAX_TRACKS].free;
                r_mx <= in_box.x; r_my <= in_box.y;
                r_mw <= in_box.w; r_mh <= in_box.h;
                r_sum <= '0;
                r_i <= '0;
                r_fld <= 2'd0;
            end
            ST_SUM: begin
                if (r_i == '0) begin
                    r_n   <= cnt[r_slot];
                    r_pos <= head[r_slot] - PW'(1);
                    r_i   <= NW'(1);
                end else begin
                    r_sum.x <= r_sum.x + SXW'($signed(cur_box.x));
                    r_sum.y <= r_sum.y + SXW'($signed(cur_box.y));
                    r_sum.w <= r_sum.w + SWW'(cur_box.w);
                    r_sum.h <= r_sum.h + SWW'(cur_box.h);
                    r_pos <= r_pos - PW'(1);
                    r_i   <= r_i + NW'(1);
                end
            end
            ST_WAIT: if (div_done) begin
                case (r_fld)
                    2'd0: r_mx <= XW'(div_q);
                    2'd1: r_my <= XW'(div_q);
                    2'd2: r_mw <= (div_q < 1) ? WW'(1) : WW'(div_q);
                    default: r_mh <= (div_q < 1) ? WW'(1) : WW'(div_q);
                endcase
                r_fld <= r_fld + 2'd1;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata = {5'd0, r_full, r_mh, r_mw, r_my, r_mx};

`ifndef ASSERT_OFF
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !s_axis_tready) else $error("busy but ready");
    a_one_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(sel)) else $error("several slots selected");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
`endif
endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// testbench for the per-track moving-average box filter: a local predictor
// keeps its own track table and rings, each output transfer is compared
// against the oldest predicted box
module tb_top
    import ptbma_pkg::*;
();

    localparam int unsigned N_TRACKS = 16;
    localparam int unsigned N_WIN = 8;
    localparam logic KIND_BOX = 1'b0;
    localparam logic KIND_EOF = 1'b1;
    // margin for a box still inside the block, so this covers any tail
    localparam int unsigned SETTLE_CYCLES = 150;

    typedef struct packed {
        logic [XW-1:0] x;
        logic [XW-1:0] y;
        logic [WW-1:0] w;
        logic [WW-1:0] h;
        logic          full;
    } t_smooth_box;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // track_id, box_x, box_y, box_w, box_h
    logic        s_axis_tuser;   // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // smooth x, y, w, h, table_full
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    per_track_box_moving_average_top dut (.*);

    // predictor copy of the track table
    int unsigned win_reg;
    bit          trk_valid [N_TRACKS];
    int unsigned trk_id    [N_TRACKS];
    bit          trk_seen  [N_TRACKS];
    int unsigned trk_count [N_TRACKS];
    int unsigned trk_head  [N_TRACKS];
    int          ring_x    [N_TRACKS][N_WIN];
    int          ring_y    [N_TRACKS][N_WIN];
    int          ring_w    [N_TRACKS][N_WIN];
    int          ring_h    [N_TRACKS][N_WIN];

    t_smooth_box pending_boxes[$];
    int          fail_count;
    int          hold_off_cycles;
    bit          no_idle;
    logic [15:0] id_pool[20];

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    initial begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // half away from zero, n >= 1
    function automatic int mean_rounded(int s, int n);
        int unsigned mag;
        int unsigned q;
        mag = (s < 0) ? -s : s;
        q = (2 * mag + n) / (2 * n);
        return (s < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic void track_end_of_frame();
        for (int i = 0; i < N_TRACKS; i++) begin
            if (!trk_seen[i]) trk_valid[i] = 1'b0;
            trk_seen[i] = 1'b0;
        end
    endfunction

    function automatic t_smooth_box track_box(int unsigned id, logic [XW-1:0] bx,
                                              logic [XW-1:0] by, logic [WW-1:0] bw,
                                              logic [WW-1:0] bh);
        t_smooth_box r;
        int slot;
        int unsigned win;
        int unsigned n;
        int unsigned pos;
        int sx, sy, sw, sh, mw, mh;
        slot = -1;
        for (int i = 0; i < N_TRACKS; i++) begin
            if (slot < 0 && trk_valid[i] && trk_id[i] == id) slot = i;
        end
        if (slot < 0) begin
            for (int i = 0; i < N_TRACKS; i++) begin
                if (slot < 0 && !trk_valid[i]) begin
                    slot = i;
                    trk_valid[i] = 1'b1;
                    trk_id[i] = id;
                    trk_seen[i] = 1'b0;
                    trk_count[i] = 0;
                    trk_head[i] = 0;
                end
            end
        end
        if (slot < 0) begin
            // no free slot: raw box goes straight through
            r = '{x: bx, y: by, w: bw, h: bh, full: 1'b1};
            return r;
        end
        trk_seen[slot] = 1'b1;
        win = (win_reg == 0) ? 1 : (win_reg > N_WIN ? N_WIN : win_reg);
        pos = trk_head[slot];
        ring_x[slot][pos] = $signed(bx);
        ring_y[slot][pos] = $signed(by);
        ring_w[slot][pos] = bw;
        ring_h[slot][pos] = bh;
        trk_head[slot] = (pos + 1) % N_WIN;
        n = trk_count[slot] + 1;
        if (n > win) n = win;
        trk_count[slot] = n;
        sx = 0; sy = 0; sw = 0; sh = 0;
        for (int i = 0; i < n; i++) begin
            sx += ring_x[slot][(pos + N_WIN - i) % N_WIN];
            sy += ring_y[slot][(pos + N_WIN - i) % N_WIN];
            sw += ring_w[slot][(pos + N_WIN - i) % N_WIN];
            sh += ring_h[slot][(pos + N_WIN - i) % N_WIN];
        end
        mw = mean_rounded(sw, n);
        mh = mean_rounded(sh, n);
        if (mw < 1) mw = 1;
        if (mh < 1) mh = 1;
        r.x = XW'(mean_rounded(sx, n));
        r.y = XW'(mean_rounded(sy, n));
        r.w = WW'(mw);
        r.h = WW'(mh);
        r.full = 1'b0;
        return r;
    endfunction

    // output side: random ready, long hold-offs on request or now and then
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                m_axis_tready = 1'b0;
                hold_off_cycles--;
            end else if (no_idle) begin
                m_axis_tready = 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                m_axis_tready = 1'b0;
                hold_off_cycles = $urandom_range(10, 40);
            end else begin
                m_axis_tready = ($urandom_range(0, 9) < 6) ? 1'b1
                              : 1'($urandom_range(0, 1));
            end
        end
    end

    // result checker on each output transfer
    always @(posedge i_clk) begin
        t_smooth_box got;
        t_smooth_box want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.x = m_axis_tdata[12:0];
            got.y = m_axis_tdata[25:13];
            got.w = m_axis_tdata[37:26];
            got.h = m_axis_tdata[49:38];
            got.full = m_axis_tdata[50];
            if (pending_boxes.size() == 0) begin
                $error("unexpected result transfer %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_boxes[0];
                pending_boxes.delete(0);
                if (got.x !== want.x) begin
                    $error("smooth_x expected %0d got %0d", $signed(want.x), $signed(got.x));
                    fail_count++;
                end
                if (got.y !== want.y) begin
                    $error("smooth_y expected %0d got %0d", $signed(want.y), $signed(got.y));
                    fail_count++;
                end
                if (got.w !== want.w) begin
                    $error("smooth_w expected %0d got %0d", want.w, got.w);
                    fail_count++;
                end
                if (got.h !== want.h) begin
                    $error("smooth_h expected %0d got %0d", want.h, got.h);
                    fail_count++;
                end
                if (got.full !== want.full) begin
                    $error("table_full expected %0b got %0b", want.full, got.full);
                    fail_count++;
                end
            end
        end
    end

    function automatic int idle_gap();
        if (no_idle) return 0;
        if ($urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // one input transfer; predicted at the accepting edge
    task automatic send_item(logic kind, logic [15:0] id, logic [XW-1:0] bx,
                             logic [XW-1:0] by, logic [WW-1:0] bw, logic [WW-1:0] bh);
        int gap;
        @(negedge i_clk);
        s_axis_tuser = kind;
        s_axis_tdata = {6'd0, bh, bw, by, bx, id};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_EOF) track_end_of_frame();
        else pending_boxes.push_back(track_box(id, bx, by, bw, bh));
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_rand_box(logic [15:0] id);
        send_item(KIND_BOX, id, XW'($urandom), XW'($urandom), WW'($urandom),
                  WW'($urandom));
    endtask

    task automatic send_eof();
        send_item(KIND_EOF, 16'($urandom), XW'($urandom), XW'($urandom),
                  WW'($urandom), WW'($urandom));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_boxes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // register write only with the block idle
    task automatic set_window(int unsigned value);
        wait_drained();
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_WINDOW[1:0];
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        win_reg = value & 4'hf;
    endtask

    // field extremes, clamps and eviction
    task automatic test_extremes();
        send_item(KIND_BOX, 16'h0000, 13'h1000, 13'h0fff, 12'd0, 12'd4095);
        send_item(KIND_BOX, 16'hffff, 13'h0fff, 13'h1000, 12'd4095, 12'd0);
        send_item(KIND_BOX, 16'h0000, 13'h1fff, 13'h0001, 12'd1, 12'd2);
        send_item(KIND_BOX, 16'h0000, 13'h1000, 13'h1000, 12'd0, 12'd0);
        // duplicate id inside one frame
        send_item(KIND_BOX, 16'hffff, 13'h0fff, 13'h0fff, 12'd4095, 12'd4095);
        send_eof();
        send_item(KIND_BOX, 16'ha5a5, 13'd3, 13'h1ffd, 12'd5, 12'd6);
        send_eof();
        // both older tracks unseen last frame, so they are gone now
        send_eof();
        send_item(KIND_BOX, 16'h0000, 13'd1, 13'd1, 12'd1, 12'd1);
        send_item(KIND_BOX, 16'h5a5a, 13'd100, 13'h1f9c, 12'd7, 12'd9);
    endtask

    // window zero, one, full, above the maximum, and shrinking
    task automatic test_window_sweep();
        int unsigned wins[6] = '{0, 1, 8, 15, 2, 4};
        foreach (wins[k]) begin
            set_window(wins[k]);
            repeat (10) send_rand_box(16'h1234);
            send_rand_box(16'h4321);
            send_eof();
        end
    endtask

    // more live tracks than slots
    task automatic test_table_full();
        send_eof();
        send_eof();
        for (int i = 0; i < 20; i++) send_rand_box(16'(16'h8000 + i * 257));
        send_rand_box(16'h8000);
        send_eof();
    endtask

    // output held off while input keeps coming, then a full drain pause and a burst with no idle gaps
    task automatic test_back_pressure();
        hold_off_cycles = 600;
        for (int i = 0; i < 12; i++) send_rand_box(id_pool[i % 4]);
        wait_drained();
        no_idle = 1'b1;
        for (int i = 0; i < 30; i++) send_rand_box(id_pool[i % 5]);
        send_eof();
        no_idle = 1'b0;
    endtask

    task automatic test_random_frames(int n_items);
        int sent;
        int frame_len;
        int unsigned wins[4] = '{0, 8, 15, 3};
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 49) == 0) begin
                set_window($urandom_range(0, 9) < 3 ? wins[$urandom_range(0, 3)]
                                                    : $urandom_range(0, 15));
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 29) == 0) id_pool[$urandom_range(0, 19)] = 16'($urandom);
            frame_len = $urandom_range(1, 18);
            for (int i = 0; i < frame_len; i++) begin
                if ($urandom_range(0, 19) == 0) send_rand_box(16'($urandom));
                else send_rand_box(id_pool[$urandom_range(0, 19)]);
            end
            // occasionally a doubled end of frame to drop everything
            if ($urandom_range(0, 15) == 0) begin
                send_eof();
                sent++;
            end
            send_eof();
            sent += frame_len + 1;
        end
    endtask

    initial begin
        fail_count = 0;
        hold_off_cycles = 0;
        no_idle = 1'b0;
        win_reg = 4;
        foreach (trk_valid[i]) begin
            trk_valid[i] = 1'b0;
            trk_seen[i] = 1'b0;
            trk_count[i] = 0;
            trk_head[i] = 0;
            trk_id[i] = 0;
        end
        foreach (id_pool[i]) id_pool[i] = 16'($urandom);
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_BOX;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        test_extremes();
        test_window_sweep();
        test_table_full();
        test_back_pressure();
        test_random_frames(1200);

        wait_drained();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
src/ptbma_pkg.sv
src/ptbma_cell.sv
src/ptbma_div.sv
src/per_track_box_moving_average_top.sv
test/tb_top.sv
